FILE: rtl/core/measure_window_qualifier_core_assert.svh
// Assertion macros used by the checker of the window qualifier.
// Both need clk_i visible where used, MWQ_ASSERT also rst_ni.
`ifndef MEASURE_WINDOW_QUALIFIER_CORE_ASSERT_SVH
`define MEASURE_WINDOW_QUALIFIER_CORE_ASSERT_SVH

// Property checked outside reset only.
`define MWQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Property checked at every edge, reset included.
`define MWQ_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/core/mwq_pkg.sv
`default_nettype none

package mwq_pkg;

  localparam int unsigned MWQ_TIME_BITS     = 48;
  localparam int unsigned MWQ_VALUE_BITS    = 32;
  localparam int unsigned MWQ_COUNT_BITS    = 16;

  // Configuration port geometry.
  localparam int unsigned MWQ_REG_IDX_BITS  = 3;
  localparam int unsigned MWQ_CFG_DATA_BITS = 64;
  // The maximum threshold sits in the upper half of the threshold pair.
  localparam int unsigned MWQ_THR_MAX_LSB   = 32;
  // Rise, fall and cross targets.
  localparam int unsigned MWQ_EVENT_SLICES  = 3;

  typedef enum logic [MWQ_REG_IDX_BITS-1:0] {
    REG_ENABLE_MASK    = 3'd0,
    REG_DELAY_TIME     = 3'd1,
    REG_FROM_TIME      = 3'd2,
    REG_TO_TIME        = 3'd3,
    REG_THRESHOLD_PAIR = 3'd4,
    REG_CROSS_LEVEL    = 3'd5,
    REG_EVENT_TARGETS  = 3'd6
  } mwq_reg_e;

  // Check enables, most significant first so that bit 0 is the delay check.
  typedef struct packed {
    logic crossing;
    logic fall;
    logic rise;
    logic max;
    logic min;
    logic to;
    logic from;
    logic delay;
  } mwq_enable_t;

  localparam int unsigned MWQ_ENABLE_BITS = $bits(mwq_enable_t);

endpackage

`default_nettype wire

FILE: rtl/core/mwq_ifs.sv
`default_nettype none

// Sample request channel.
interface mwq_sample_if
  import mwq_pkg::*;
#(
  parameter int unsigned TIME_BITS  = MWQ_TIME_BITS,
  parameter int unsigned VALUE_BITS = MWQ_VALUE_BITS
);
  logic                         valid;
  logic                         ready;
  logic [TIME_BITS-1:0]         sample_time;
  logic signed [VALUE_BITS-1:0] sample_value;

  modport source (output valid, output sample_time, output sample_value, input ready);
  modport sink   (input valid, input sample_time, input sample_value, output ready);
endinterface

// Result request channel.
interface mwq_result_if
  import mwq_pkg::*;
#(
  parameter int unsigned COUNT_BITS = MWQ_COUNT_BITS
);
  logic                  valid;
  logic                  ready;
  logic                  after_delay;
  logic                  in_time_window;
  logic                  in_event_window;
  logic                  in_thresholds;
  logic [COUNT_BITS-1:0] rises_seen;
  logic [COUNT_BITS-1:0] falls_seen;
  logic [COUNT_BITS-1:0] crosses_seen;

  modport source (output valid, output after_delay, output in_time_window,
                  output in_event_window, output in_thresholds, output rises_seen,
                  output falls_seen, output crosses_seen, input ready);
  modport sink   (input valid, input after_delay, input in_time_window,
                  input in_event_window, input in_thresholds, input rises_seen,
                  input falls_seen, input crosses_seen, output ready);
endinterface

// Configuration write channel.
interface mwq_cfg_if
  import mwq_pkg::*;
;
  logic                         valid;
  logic                         ready;
  logic [MWQ_REG_IDX_BITS-1:0]  index;
  logic [MWQ_CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/mwq_cfg_regs.sv
`default_nettype none

module mwq_cfg_regs
  import mwq_pkg::*;
#(
  parameter int unsigned TIME_BITS  = MWQ_TIME_BITS,
  parameter int unsigned VALUE_BITS = MWQ_VALUE_BITS,
  parameter int unsigned COUNT_BITS = MWQ_COUNT_BITS
) (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  mwq_cfg_if.sink                                  cfg_i,
  output mwq_enable_t                              enable_o,
  output logic [TIME_BITS-1:0]                     delay_time_o,
  output logic [TIME_BITS-1:0]                     from_time_o,
  output logic [TIME_BITS-1:0]                     to_time_o,
  output logic signed [VALUE_BITS-1:0]             thr_min_o,
  output logic signed [VALUE_BITS-1:0]             thr_max_o,
  output logic signed [VALUE_BITS-1:0]             cross_level_o,
  output logic [MWQ_EVENT_SLICES*COUNT_BITS-1:0]   targets_o
);

  mwq_enable_t                            enable_q;
  logic [TIME_BITS-1:0]                   delay_q, from_q, to_q;
  logic signed [VALUE_BITS-1:0]           thr_min_q, thr_max_q, level_q;
  logic [MWQ_EVENT_SLICES*COUNT_BITS-1:0] targets_q;
  logic                                   wr_en;

  // Writes are taken in every cycle.
  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= '0;
      delay_q   <= '0;
      from_q    <= '0;
      to_q      <= '0;
      thr_min_q <= '0;
      thr_max_q <= '0;
      level_q   <= '0;
      targets_q <= '0;
    end else if (wr_en) begin
      case (mwq_reg_e'(cfg_i.index))
        REG_ENABLE_MASK:    enable_q  <= mwq_enable_t'(cfg_i.data[MWQ_ENABLE_BITS-1:0]);
        REG_DELAY_TIME:     delay_q   <= cfg_i.data[TIME_BITS-1:0];
        REG_FROM_TIME:      from_q    <= cfg_i.data[TIME_BITS-1:0];
        REG_TO_TIME:        to_q      <= cfg_i.data[TIME_BITS-1:0];
        REG_THRESHOLD_PAIR: begin
          thr_min_q <= cfg_i.data[VALUE_BITS-1:0];
          thr_max_q <= cfg_i.data[MWQ_THR_MAX_LSB +: VALUE_BITS];
        end
        REG_CROSS_LEVEL:    level_q   <= cfg_i.data[VALUE_BITS-1:0];
        REG_EVENT_TARGETS:  targets_q <= cfg_i.data[MWQ_EVENT_SLICES*COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign enable_o      = enable_q;
  assign delay_time_o  = delay_q;
  assign from_time_o   = from_q;
  assign to_time_o     = to_q;
  assign thr_min_o     = thr_min_q;
  assign thr_max_o     = thr_max_q;
  assign cross_level_o = level_q;
  assign targets_o     = targets_q;

endmodule

`default_nettype wire

FILE: rtl/core/mwq_event_unit.sv
`default_nettype none

module mwq_event_unit
  import mwq_pkg::*;
#(
  parameter int unsigned VALUE_BITS = MWQ_VALUE_BITS,
  parameter int unsigned COUNT_BITS = MWQ_COUNT_BITS
) (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire                                     step_i,
  input  wire signed [VALUE_BITS-1:0]             value_i,
  input  wire signed [VALUE_BITS-1:0]             level_i,
  input  mwq_enable_t                             enable_i,
  input  wire [MWQ_EVENT_SLICES*COUNT_BITS-1:0]   targets_i,
  output logic [COUNT_BITS-1:0]                   rises_o,
  output logic [COUNT_BITS-1:0]                   falls_o,
  output logic [COUNT_BITS-1:0]                   crosses_o,
  output logic                                    event_ok_o
);

  localparam logic [COUNT_BITS-1:0] CntAny = '1;
  localparam logic [COUNT_BITS-1:0] CntMax = CntAny - COUNT_BITS'(1);

  logic signed [VALUE_BITS-1:0] prev_q;
  logic                         rising_q, rising_d, falling_q, falling_d;
  logic [COUNT_BITS-1:0]        rise_q, rise_d, fall_q, fall_d, cross_q, cross_d;
  logic                         any_ev, rise_start, fall_start, crossed;
  logic [COUNT_BITS-1:0]        tgt_rise, tgt_fall, tgt_cross;

  assign any_ev     = enable_i.rise | enable_i.fall | enable_i.crossing;
  assign rise_start = (value_i > prev_q) && !rising_q;
  assign fall_start = (value_i < prev_q) && !falling_q;
  assign crossed    = ((value_i < level_i) && (prev_q > level_i)) ||
                      ((value_i > level_i) && (prev_q < level_i));

  // Counters stop one short of all ones, which is kept for the "any" target.
  assign rise_d  = (rise_start && rise_q < CntMax) ? rise_q + COUNT_BITS'(1) : rise_q;
  assign fall_d  = (fall_start && fall_q < CntMax) ? fall_q + COUNT_BITS'(1) : fall_q;
  assign cross_d = (crossed && cross_q < CntMax) ? cross_q + COUNT_BITS'(1) : cross_q;

  assign rising_d  = rise_start ? 1'b1 : (fall_start ? 1'b0 : rising_q);
  assign falling_d = fall_start ? 1'b1 : (rise_start ? 1'b0 : falling_q);

  assign tgt_rise  = targets_i[0*COUNT_BITS +: COUNT_BITS];
  assign tgt_fall  = targets_i[1*COUNT_BITS +: COUNT_BITS];
  assign tgt_cross = targets_i[2*COUNT_BITS +: COUNT_BITS];

  // With every event check disabled the state is frozen and shown as it is.
  assign rises_o   = any_ev ? rise_d  : rise_q;
  assign falls_o   = any_ev ? fall_d  : fall_q;
  assign crosses_o = any_ev ? cross_d : cross_q;

  assign event_ok_o = !any_ev ||
    (enable_i.rise     && (tgt_rise  == CntAny || tgt_rise  == rise_d))  ||
    (enable_i.fall     && (tgt_fall  == CntAny || tgt_fall  == fall_d))  ||
    (enable_i.crossing && (tgt_cross == CntAny || tgt_cross == cross_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      rising_q  <= 1'b0;
      falling_q <= 1'b0;
      rise_q    <= '0;
      fall_q    <= '0;
      cross_q   <= '0;
    end else if (step_i && any_ev) begin
      prev_q    <= value_i;
      rising_q  <= rising_d;
      falling_q <= falling_d;
      rise_q    <= rise_d;
      fall_q    <= fall_d;
      cross_q   <= cross_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/measure_window_qualifier_core.sv
// Path: an accepted sample passes the sample register, then the result register.
// Throughput: one sample per cycle while the result side keeps pace, set by the
// single pass through the comparators and event counters into the result register.
// Reset: asynchronous, active low; clears the settings, the event state and the
// valid flags. No clearing pass is needed, so samples are taken right after reset.
`default_nettype none

module measure_window_qualifier_core
  import mwq_pkg::*;
#(
  parameter int unsigned TIME_BITS  = MWQ_TIME_BITS,
  parameter int unsigned VALUE_BITS = MWQ_VALUE_BITS,
  parameter int unsigned COUNT_BITS = MWQ_COUNT_BITS
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  mwq_sample_if.sink     sample_i,
  mwq_result_if.source   result_o,
  mwq_cfg_if.sink        cfg_i
);

  // Configuration as held by the register block.
  mwq_enable_t                            enable;
  logic [TIME_BITS-1:0]                   delay_time, from_time, to_time;
  logic signed [VALUE_BITS-1:0]           thr_min, thr_max, cross_level;
  logic [MWQ_EVENT_SLICES*COUNT_BITS-1:0] targets;

  // Sample register: the first stage of the pass.
  logic                         s1_valid_q, s1_valid_d;
  logic [TIME_BITS-1:0]         s1_time_q;
  logic signed [VALUE_BITS-1:0] s1_value_q;

  // Result register: the second stage, which faces the result channel.
  logic                  res_valid_q, res_valid_d;
  logic                  res_delay_q, res_delay_d;
  logic                  res_time_q, res_time_d;
  logic                  res_event_q, res_event_d;
  logic                  res_thr_q, res_thr_d;
  logic [COUNT_BITS-1:0] res_rise_q, res_fall_q, res_cross_q;

  logic                  sample_take, advance;
  logic [COUNT_BITS-1:0] ev_rises, ev_falls, ev_crosses;
  logic                  ev_ok;

  mwq_cfg_regs #(
    .TIME_BITS  (TIME_BITS),
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_cfg_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_i),
    .enable_o      (enable),
    .delay_time_o  (delay_time),
    .from_time_o   (from_time),
    .to_time_o     (to_time),
    .thr_min_o     (thr_min),
    .thr_max_o     (thr_max),
    .cross_level_o (cross_level),
    .targets_o     (targets)
  );

  // The sample moves on when the result register is empty or is being emptied
  // in this very cycle. The sample register then frees up too, so a new request
  // is taken every cycle while the result side keeps pace; when the result side
  // stalls, one sample waits here and one result waits at the output.
  assign advance         = s1_valid_q && (!res_valid_q || result_o.ready);
  assign sample_i.ready  = !s1_valid_q || advance;
  assign sample_take     = sample_i.valid && sample_i.ready;

  assign s1_valid_d  = sample_take ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
  assign res_valid_d = advance ? 1'b1 : (result_o.ready ? 1'b0 : res_valid_q);

  // Window checks. Each disabled check passes; inverted windows simply fail.
  assign res_delay_d = !(enable.delay && (s1_time_q < delay_time));
  assign res_time_d  = !((enable.from && (s1_time_q < from_time)) ||
                         (enable.to   && (s1_time_q > to_time)));
  assign res_thr_d   = !((enable.min && (s1_value_q < thr_min)) ||
                         (enable.max && (s1_value_q > thr_max)));
  assign res_event_d = ev_ok;

  // The event state is updated only when the sample leaves for the result
  // register, so a stalled sample is counted exactly once.
  mwq_event_unit #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_event_unit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .value_i    (s1_value_q),
    .level_i    (cross_level),
    .enable_i   (enable),
    .targets_i  (targets),
    .rises_o    (ev_rises),
    .falls_o    (ev_falls),
    .crosses_o  (ev_crosses),
    .event_ok_o (ev_ok)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers carry no reset; they are only read behind their valid flag.
  always_ff @(posedge clk_i) begin
    if (sample_take) begin
      s1_time_q  <= sample_i.sample_time;
      s1_value_q <= sample_i.sample_value;
    end
    if (advance) begin
      res_delay_q <= res_delay_d;
      res_time_q  <= res_time_d;
      res_event_q <= res_event_d;
      res_thr_q   <= res_thr_d;
      res_rise_q  <= ev_rises;
      res_fall_q  <= ev_falls;
      res_cross_q <= ev_crosses;
    end
  end

  assign result_o.valid           = res_valid_q;
  assign result_o.after_delay     = res_delay_q;
  assign result_o.in_time_window  = res_time_q;
  assign result_o.in_event_window = res_event_q;
  assign result_o.in_thresholds   = res_thr_q;
  assign result_o.rises_seen      = res_rise_q;
  assign result_o.falls_seen      = res_fall_q;
  assign result_o.crosses_seen    = res_cross_q;

endmodule

`default_nettype wire

FILE: rtl/core/mwq_checker.sv
`default_nettype none
`include "measure_window_qualifier_core_assert.svh"

module mwq_checker
  import mwq_pkg::*;
#(
  parameter int unsigned COUNT_BITS = MWQ_COUNT_BITS
) (
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  res_valid_i,
  input wire                  res_ready_i,
  input wire [COUNT_BITS-1:0] rises_i,
  input wire [COUNT_BITS-1:0] falls_i,
  input wire [COUNT_BITS-1:0] crosses_i
);

  localparam logic [COUNT_BITS-1:0] CntAny = '1;

  logic [COUNT_BITS-1:0] last_rise_q, last_fall_q, last_cross_q;

  // Counts of the last result delivered; the counters only ever go up.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_rise_q  <= '0;
      last_fall_q  <= '0;
      last_cross_q <= '0;
    end else if (res_valid_i && res_ready_i) begin
      last_rise_q  <= rises_i;
      last_fall_q  <= falls_i;
      last_cross_q <= crosses_i;
    end
  end

  `MWQ_ASSERT_RST(a_no_result_in_reset, !rst_ni |-> !res_valid_i,
    "result shown during reset")
  `MWQ_ASSERT(a_result_held,
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(rises_i) &&
    $stable(falls_i) && $stable(crosses_i), "stalled result changed")
  `MWQ_ASSERT(a_count_not_any,
    res_valid_i |-> rises_i != CntAny && falls_i != CntAny && crosses_i != CntAny,
    "count reached the any code")
  `MWQ_ASSERT(a_count_monotone,
    res_valid_i |-> rises_i >= last_rise_q && falls_i >= last_fall_q &&
    crosses_i >= last_cross_q, "event count went down")

endmodule

bind measure_window_qualifier_core mwq_checker #(
  .COUNT_BITS (COUNT_BITS)
) u_mwq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (result_o.valid),
  .res_ready_i (result_o.ready),
  .rises_i     (result_o.rises_seen),
  .falls_i     (result_o.falls_seen),
  .crosses_i   (result_o.crosses_seen)
);

`default_nettype wire
